FILE: design/gtu_pkg.sv
// shared types, codes and control structs for the graph traversal unit
package gtu_pkg;

	localparam int VTX_W  = 6;
	localparam int ACT_W  = 2;
	localparam int VCNT_W = 7;

	localparam logic [ACT_W-1:0] ACT_EDGE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DFS  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BFS  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	localparam logic ST_VISIT  = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [VTX_W-1:0] first_vertex;
		logic [VTX_W-1:0] second_vertex;
	} in_beat_t;

	typedef struct packed {
		logic             status;
		logic [VTX_W-1:0] vertex;
		logic             last;
	} out_beat_t;

	typedef enum logic [4:0] {
		S_CLR_RST,
		S_IDLE,
		S_DECODE,
		S_EA,
		S_EB,
		S_EC,
		S_ECHK,
		S_EWA,
		S_EWB,
		S_WCLR,
		S_WINIT,
		S_POP,
		S_PRD,
		S_VRD,
		S_VCHK,
		S_NRD,
		S_NPUSH,
		S_FIN,
		S_REJ
	} state_t;

	typedef struct packed {
		logic load_item;
		logic clr_step;
		logic clr_deg;
		logic rd_deg_a;
		logic rd_deg_b;
		logic cap_da;
		logic cap_db;
		logic wr_edge_a;
		logic wr_edge_b;
		logic walk_init;
		logic pop;
		logic cap_d;
		logic visit;
		logic nb_push;
		logic emit_rej;
		logic emit_fin;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic bad;
		logic is_edge;
		logic edge_ok;
		logic empty;
		logic skip;
		logic nb_done;
		logic out_free;
		logic hold_valid;
	} sts_t;

endpackage

FILE: design/graph_traversal_dfs_bfs_unit.sv
// top level: undirected graph store with depth-first and breadth-first walks
// edge load: read both degrees, check room, write both adjacency entries; one item in flight
// an item with a bad id or action is rejected at decode, one with a full list after the degree check
// walk: clear visited store, load start vertex, then read and check each popped entry and push
//   the neighbors of each new vertex, all paced by registered store reads
// a new item is taken while a result waits; after reset a pass zeroes degree and visited stores
module graph_traversal_dfs_bfs_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_DEGREE   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  gtu_pkg::in_beat_t          in_beat,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gtu_pkg::out_beat_t         out_beat,
	input  logic                       cfg_we,
	input  logic [gtu_pkg::VCNT_W-1:0] cfg_data
);

	gtu_pkg::cmd_t cmd;
	gtu_pkg::sts_t sts;

	gtu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	gtu_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_beat), .cfg_we(cfg_we),
		.cfg_data(cfg_data), .out_beat(out_beat), .out_valid(out_valid),
		.out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

endmodule

FILE: design/gtu_ram.sv
// generic simple dual port ram with registered read
module gtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/gtu_ctrl.sv
// sequencing state machine for edge loads and walks
module gtu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  gtu_pkg::sts_t sts,
	output gtu_pkg::cmd_t cmd
);

	gtu_pkg::state_t state_q;
	gtu_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtu_pkg::S_CLR_RST;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gtu_pkg::S_CLR_RST: if (sts.clr_done) state_d = gtu_pkg::S_IDLE;
			gtu_pkg::S_IDLE:    if (in_valid) state_d = gtu_pkg::S_DECODE;
			gtu_pkg::S_DECODE: begin
				priority if (sts.bad) state_d = gtu_pkg::S_REJ;
				else if (sts.is_edge) state_d = gtu_pkg::S_EA;
				else state_d = gtu_pkg::S_WCLR;
			end
			gtu_pkg::S_EA:      state_d = gtu_pkg::S_EB;
			gtu_pkg::S_EB:      state_d = gtu_pkg::S_EC;
			gtu_pkg::S_EC:      state_d = gtu_pkg::S_ECHK;
			gtu_pkg::S_ECHK:    state_d = sts.edge_ok ? gtu_pkg::S_EWA : gtu_pkg::S_REJ;
			gtu_pkg::S_EWA:     state_d = gtu_pkg::S_EWB;
			gtu_pkg::S_EWB:     state_d = gtu_pkg::S_IDLE;
			gtu_pkg::S_WCLR:    if (sts.clr_done) state_d = gtu_pkg::S_WINIT;
			gtu_pkg::S_WINIT:   state_d = gtu_pkg::S_POP;
			gtu_pkg::S_POP:     state_d = sts.empty ? gtu_pkg::S_FIN : gtu_pkg::S_PRD;
			gtu_pkg::S_PRD:     state_d = gtu_pkg::S_VRD;
			gtu_pkg::S_VRD:     state_d = gtu_pkg::S_VCHK;
			gtu_pkg::S_VCHK: begin
				priority if (sts.skip) state_d = gtu_pkg::S_POP;
				else if (!sts.hold_valid || sts.out_free) state_d = gtu_pkg::S_NRD;
				else state_d = gtu_pkg::S_VCHK;
			end
			gtu_pkg::S_NRD:     state_d = sts.nb_done ? gtu_pkg::S_POP : gtu_pkg::S_NPUSH;
			gtu_pkg::S_NPUSH:   state_d = gtu_pkg::S_NRD;
			gtu_pkg::S_FIN: begin
				if (!sts.hold_valid || sts.out_free) state_d = gtu_pkg::S_IDLE;
			end
			gtu_pkg::S_REJ:     if (sts.out_free) state_d = gtu_pkg::S_IDLE;
			default:            state_d = gtu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			gtu_pkg::S_CLR_RST: begin
				cmd.clr_step = 1'b1;
				cmd.clr_deg  = 1'b1;
			end
			gtu_pkg::S_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_item = in_valid;
			end
			gtu_pkg::S_EA:    cmd.rd_deg_a = 1'b1;
			gtu_pkg::S_EB: begin
				cmd.rd_deg_b = 1'b1;
				cmd.cap_da   = 1'b1;
			end
			gtu_pkg::S_EC:    cmd.cap_db = 1'b1;
			gtu_pkg::S_EWA:   cmd.wr_edge_a = 1'b1;
			gtu_pkg::S_EWB:   cmd.wr_edge_b = 1'b1;
			gtu_pkg::S_WCLR:  cmd.clr_step = 1'b1;
			gtu_pkg::S_WINIT: cmd.walk_init = 1'b1;
			gtu_pkg::S_POP:   cmd.pop = !sts.empty;
			gtu_pkg::S_PRD:   cmd.cap_d = 1'b1;
			gtu_pkg::S_VCHK:  cmd.visit = !sts.skip && (!sts.hold_valid || sts.out_free);
			gtu_pkg::S_NPUSH: cmd.nb_push = 1'b1;
			gtu_pkg::S_FIN:   cmd.emit_fin = !sts.hold_valid || sts.out_free;
			gtu_pkg::S_REJ:   cmd.emit_rej = sts.out_free;
			default:          cmd = '0;
		endcase
	end

endmodule

FILE: design/gtu_dp.sv
// datapath: adjacency, degree, visited and pending stores, result register
module gtu_dp #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_DEGREE   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gtu_pkg::in_beat_t              in_beat,
	input  logic                           cfg_we,
	input  logic [gtu_pkg::VCNT_W-1:0]     cfg_data,
	output gtu_pkg::out_beat_t             out_beat,
	output logic                           out_valid,
	input  logic                           out_stall,
	input  gtu_pkg::cmd_t                  cmd,
	output gtu_pkg::sts_t                  sts
);

	localparam int PD  = MAX_VERTICES * MAX_DEGREE;
	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int DW  = $clog2(MAX_DEGREE + 1);
	localparam int NAW = $clog2(PD);
	localparam int PCW = $clog2(PD + 1);

	logic [gtu_pkg::VCNT_W-1:0] vcount_q;
	gtu_pkg::in_beat_t          item_q;
	logic [VAW-1:0]             clr_q;
	logic [gtu_pkg::VTX_W-1:0]  d_q;
	logic [DW-1:0]              da_q;
	logic [DW-1:0]              db_q;
	logic [DW-1:0]              deg_q;
	logic [DW-1:0]              i_q;
	logic [NAW-1:0]             head_q;
	logic [NAW-1:0]             tail_q;
	logic [PCW-1:0]             cnt_q;
	logic [gtu_pkg::VTX_W-1:0]  hold_q;
	logic                       hold_valid_q;
	gtu_pkg::out_beat_t         out_q;
	logic                       out_valid_q;

	logic [gtu_pkg::VTX_W-1:0] a;
	logic [gtu_pkg::VTX_W-1:0] b;
	logic                      self_loop;
	logic                      a_bad;
	logic                      b_bad;
	logic                      is_dfs;
	logic                      out_free;
	logic                      push_ok;
	logic [NAW-1:0]            tail_m1;
	logic [NAW-1:0]            tail_p1;
	logic [NAW-1:0]            head_p1;

	logic                      deg_we;
	logic [VAW-1:0]            deg_waddr;
	logic [DW-1:0]             deg_wdata;
	logic [VAW-1:0]            deg_raddr;
	logic [DW-1:0]             deg_rd;
	logic                      vis_we;
	logic [VAW-1:0]            vis_waddr;
	logic                      vis_rd;
	logic                      nbr_we;
	logic [NAW-1:0]            nbr_waddr;
	logic [gtu_pkg::VTX_W-1:0] nbr_wdata;
	logic [NAW-1:0]            nbr_raddr;
	logic [gtu_pkg::VTX_W-1:0] nbr_rd;
	logic                      pnd_we;
	logic [NAW-1:0]            pnd_waddr;
	logic [gtu_pkg::VTX_W-1:0] pnd_wdata;
	logic [NAW-1:0]            pnd_raddr;
	logic [gtu_pkg::VTX_W-1:0] pnd_rd;

	assign a         = item_q.first_vertex;
	assign b         = item_q.second_vertex;
	assign self_loop = (a == b);
	assign is_dfs    = (item_q.action == gtu_pkg::ACT_DFS);
	assign a_bad     = (7'(a) >= vcount_q) || (32'(a) >= MAX_VERTICES);
	assign b_bad     = (7'(b) >= vcount_q) || (32'(b) >= MAX_VERTICES);
	assign out_free  = !out_valid_q || !out_stall;
	assign push_ok   = (cnt_q != PCW'(PD));
	assign tail_m1   = (tail_q == '0) ? NAW'(PD - 1) : tail_q - NAW'(1);
	assign tail_p1   = (tail_q == NAW'(PD - 1)) ? '0 : tail_q + NAW'(1);
	assign head_p1   = (head_q == NAW'(PD - 1)) ? '0 : head_q + NAW'(1);

	always_comb begin
		sts.clr_done   = (clr_q == VAW'(MAX_VERTICES - 1));
		sts.bad        = (item_q.action == gtu_pkg::ACT_NONE) || a_bad
			|| ((item_q.action == gtu_pkg::ACT_EDGE) && b_bad);
		sts.is_edge    = (item_q.action == gtu_pkg::ACT_EDGE);
		sts.edge_ok    = self_loop ? (32'(da_q) + 2 <= MAX_DEGREE)
			: ((32'(da_q) < MAX_DEGREE) && (32'(db_q) < MAX_DEGREE));
		sts.empty      = (cnt_q == '0);
		sts.skip       = vis_rd || (32'(d_q) >= MAX_VERTICES);
		sts.nb_done    = (i_q == deg_q);
		sts.out_free   = out_free;
		sts.hold_valid = hold_valid_q;
	end

	// degree store
	always_comb begin
		deg_we    = (cmd.clr_step && cmd.clr_deg) || cmd.wr_edge_a || cmd.wr_edge_b;
		deg_waddr = clr_q;
		deg_wdata = '0;
		if (cmd.wr_edge_a) begin
			deg_waddr = VAW'(a);
			deg_wdata = da_q + DW'(1);
		end else if (cmd.wr_edge_b) begin
			deg_waddr = self_loop ? VAW'(a) : VAW'(b);
			deg_wdata = self_loop ? da_q + DW'(2) : db_q + DW'(1);
		end
		priority if (cmd.rd_deg_a) deg_raddr = VAW'(a);
		else if (cmd.rd_deg_b) deg_raddr = VAW'(b);
		else deg_raddr = VAW'(d_q);
	end

	assign vis_we    = cmd.clr_step || cmd.visit;
	assign vis_waddr = cmd.clr_step ? clr_q : VAW'(d_q);

	always_comb begin
		nbr_we    = cmd.wr_edge_a || cmd.wr_edge_b;
		nbr_waddr = NAW'(32'(a) * MAX_DEGREE + 32'(da_q));
		nbr_wdata = b;
		if (cmd.wr_edge_b) begin
			nbr_wdata = a;
			nbr_waddr = self_loop ? NAW'(32'(a) * MAX_DEGREE + 32'(da_q) + 1)
				: NAW'(32'(b) * MAX_DEGREE + 32'(db_q));
		end
	end
	assign nbr_raddr = NAW'(32'(d_q) * MAX_DEGREE + 32'(i_q));

	assign pnd_we    = cmd.walk_init || (cmd.nb_push && push_ok);
	assign pnd_waddr = cmd.walk_init ? '0 : tail_q;
	assign pnd_wdata = cmd.walk_init ? a : nbr_rd;
	assign pnd_raddr = is_dfs ? tail_m1 : head_q;

	gtu_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg (
		.clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
		.raddr(deg_raddr), .rdata(deg_rd)
	);

	gtu_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(!cmd.clr_step),
		.raddr(VAW'(d_q)), .rdata(vis_rd)
	);

	gtu_ram #(.WIDTH(gtu_pkg::VTX_W), .DEPTH(PD)) u_nbr (
		.clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
		.raddr(nbr_raddr), .rdata(nbr_rd)
	);

	gtu_ram #(.WIDTH(gtu_pkg::VTX_W), .DEPTH(PD)) u_pnd (
		.clk(clk), .we(pnd_we), .waddr(pnd_waddr), .wdata(pnd_wdata),
		.raddr(pnd_raddr), .rdata(pnd_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= gtu_pkg::VCNT_RESET;
			clr_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			cnt_q        <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) vcount_q <= cfg_data;
			if (cmd.load_item) clr_q <= '0;
			else if (cmd.clr_step) clr_q <= clr_q + VAW'(1);
			if (cmd.walk_init) begin
				head_q <= '0;
				tail_q <= NAW'(1);
				cnt_q  <= PCW'(1);
			end else if (cmd.pop) begin
				if (is_dfs) tail_q <= tail_m1;
				else head_q <= head_p1;
				cnt_q <= cnt_q - PCW'(1);
			end else if (cmd.nb_push && push_ok) begin
				tail_q <= tail_p1;
				cnt_q  <= cnt_q + PCW'(1);
			end
			if (cmd.visit) hold_valid_q <= 1'b1;
			else if (cmd.emit_fin) hold_valid_q <= 1'b0;
			if (cmd.emit_rej || cmd.emit_fin || (cmd.visit && hold_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= in_beat;
		if (cmd.cap_da) da_q <= deg_rd;
		if (cmd.cap_db) db_q <= deg_rd;
		if (cmd.cap_d) d_q <= pnd_rd;
		if (cmd.visit) begin
			hold_q <= d_q;
			deg_q  <= deg_rd;
			i_q    <= '0;
		end else if (cmd.nb_push) begin
			i_q <= i_q + DW'(1);
		end
		priority if (cmd.emit_rej) begin
			out_q <= '{status: gtu_pkg::ST_REJECT, vertex: '0, last: 1'b1};
		end else if (cmd.emit_fin) begin
			out_q <= '{status: gtu_pkg::ST_VISIT, vertex: hold_q, last: 1'b1};
		end else if (cmd.visit && hold_valid_q) begin
			out_q <= '{status: gtu_pkg::ST_VISIT, vertex: hold_q, last: 1'b0};
		end else begin
			out_q <= out_q;
		end
	end

	assign out_beat  = out_q;
	assign out_valid = out_valid_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PCW'(PD))
		else $error("pending occupancy above store depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cnt_q != '0))
		else $error("pop from empty pending store");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_rej || cmd.emit_fin || (cmd.visit && hold_valid_q)) |-> out_free)
		else $error("result register overwritten while held");

	a_hold_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.visit |=> hold_valid_q)
		else $error("visited vertex not held");

endmodule

FILE: bench/tb_top.sv
// testbench for the graph traversal unit: directed and random edge loads and walks
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = 64;
	localparam int ND = 16;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	gtu_pkg::in_beat_t in_beat;
	logic out_valid;
	logic out_stall;
	gtu_pkg::out_beat_t out_beat;
	logic cfg_we;
	logic [gtu_pkg::VCNT_W-1:0] cfg_data;

	graph_traversal_dfs_bfs_unit #(.MAX_VERTICES(NV), .MAX_DEGREE(ND)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// graph model
	logic [gtu_pkg::VCNT_W-1:0] vcount;
	logic [gtu_pkg::VTX_W-1:0] adj [NV][ND];
	int degree [NV];
	gtu_pkg::out_beat_t expected_q [$];
	int errors;
	int idle_pct;
	int hold_cycles;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic gtu_pkg::out_beat_t mk(input logic st,
		input logic [gtu_pkg::VTX_W-1:0] v, input logic l);
		gtu_pkg::out_beat_t r;
		r.status = st;
		r.vertex = v;
		r.last = l;
		return r;
	endfunction

	task automatic predict_walk(input int start, input bit depth_first);
		bit seen [NV];
		int pend [$];
		int d;
		foreach (seen[i]) seen[i] = 0;
		pend = {pend, start};
		while (pend.size() > 0) begin
			if (depth_first) begin
				d = pend[$];
				pend.delete(pend.size() - 1);
			end else d = pend.pop_front();
			if (seen[d]) continue;
			seen[d] = 1;
			expected_q = {expected_q, mk(gtu_pkg::ST_VISIT, d[gtu_pkg::VTX_W-1:0], 1'b0)};
			for (int i = 0; i < degree[d]; i++) pend = {pend, int'(adj[d][i])};
		end
		expected_q[$].last = 1'b1;
	endtask

	task automatic predict_item(input gtu_pkg::in_beat_t b);
		int lim;
		int a;
		int c;
		lim = (vcount < NV) ? int'(vcount) : NV;
		a = b.first_vertex;
		c = b.second_vertex;
		if (b.action == gtu_pkg::ACT_EDGE) begin
			if (a >= lim || c >= lim)
				expected_q = {expected_q, mk(gtu_pkg::ST_REJECT, '0, 1'b1)};
			else if (a == c) begin
				if (degree[a] + 2 > ND)
					expected_q = {expected_q, mk(gtu_pkg::ST_REJECT, '0, 1'b1)};
				else begin
					adj[a][degree[a]] = a[gtu_pkg::VTX_W-1:0];
					degree[a] = degree[a] + 1;
					adj[a][degree[a]] = a[gtu_pkg::VTX_W-1:0];
					degree[a] = degree[a] + 1;
				end
			end else if (degree[a] >= ND || degree[c] >= ND)
				expected_q = {expected_q, mk(gtu_pkg::ST_REJECT, '0, 1'b1)};
			else begin
				adj[a][degree[a]] = c[gtu_pkg::VTX_W-1:0];
				degree[a] = degree[a] + 1;
				adj[c][degree[c]] = a[gtu_pkg::VTX_W-1:0];
				degree[c] = degree[c] + 1;
			end
		end else if (b.action == gtu_pkg::ACT_NONE || a >= lim)
			expected_q = {expected_q, mk(gtu_pkg::ST_REJECT, '0, 1'b1)};
		else predict_walk(a, b.action == gtu_pkg::ACT_DFS);
	endtask

	// one beat on the input channel
	task automatic send_item(input logic [gtu_pkg::ACT_W-1:0] act, input int a, input int b);
		gtu_pkg::in_beat_t bt;
		bt.action = act;
		bt.first_vertex = a[gtu_pkg::VTX_W-1:0];
		bt.second_vertex = b[gtu_pkg::VTX_W-1:0];
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= bt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_item(bt);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() > 0) @(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic write_vcount(input int v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v[gtu_pkg::VCNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		vcount = v[gtu_pkg::VCNT_W-1:0];
	endtask

	task automatic test_directed();
		send_item(gtu_pkg::ACT_DFS, 0, 0);
		send_item(gtu_pkg::ACT_EDGE, 0, 1);
		send_item(gtu_pkg::ACT_EDGE, 0, 2);
		send_item(gtu_pkg::ACT_EDGE, 1, 3);
		send_item(gtu_pkg::ACT_EDGE, 2, 2);
		send_item(gtu_pkg::ACT_EDGE, 63, 0);
		send_item(gtu_pkg::ACT_EDGE, 63, 62);
		send_item(gtu_pkg::ACT_DFS, 0, 63);
		send_item(gtu_pkg::ACT_BFS, 0, 0);
		send_item(gtu_pkg::ACT_BFS, 63, 17);
		send_item(gtu_pkg::ACT_NONE, 5, 42);
		for (int i = 0; i < 8; i++) send_item(gtu_pkg::ACT_EDGE, 5, 5);
		send_item(gtu_pkg::ACT_EDGE, 5, 6);
		send_item(gtu_pkg::ACT_DFS, 5, 0);
	endtask

	task automatic test_limit();
		write_vcount(1);
		send_item(gtu_pkg::ACT_EDGE, 0, 0);
		send_item(gtu_pkg::ACT_EDGE, 0, 1);
		send_item(gtu_pkg::ACT_DFS, 1, 0);
		send_item(gtu_pkg::ACT_BFS, 0, 0);
		write_vcount(127);
		send_item(gtu_pkg::ACT_EDGE, 63, 40);
		send_item(gtu_pkg::ACT_BFS, 40, 0);
		write_vcount(20);
		send_item(gtu_pkg::ACT_DFS, 0, 0);
		send_item(gtu_pkg::ACT_EDGE, 19, 20);
	endtask

	task automatic test_random(input int count, input int span);
		int r;
		int x;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			x = $urandom;
			if (r < 60)
				send_item(gtu_pkg::ACT_EDGE, $urandom_range(span - 1), $urandom_range(span - 1));
			else if (r < 78) send_item(gtu_pkg::ACT_DFS, $urandom_range(span - 1), $urandom);
			else if (r < 96) send_item(gtu_pkg::ACT_BFS, $urandom_range(span - 1), $urandom);
			else send_item(x[gtu_pkg::ACT_W-1:0], $urandom, $urandom);
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 6; i++) send_item(gtu_pkg::ACT_BFS, $urandom_range(63), 0);
		for (int i = 0; i < 6; i++)
			send_item(gtu_pkg::ACT_EDGE, $urandom_range(63), $urandom_range(63));
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) report("result with nothing expected");
			else begin
				gtu_pkg::out_beat_t e;
				e = expected_q.pop_front();
				if (out_beat.status !== e.status)
					report($sformatf("status got %b exp %b", out_beat.status, e.status));
				if (out_beat.vertex !== e.vertex)
					report($sformatf("vertex got %0d exp %0d", out_beat.vertex, e.vertex));
				if (out_beat.last !== e.last)
					report($sformatf("last got %b exp %b", out_beat.last, e.last));
			end
		end
	end

	// receiver stall
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// watchdog
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("FAIL graph_traversal_dfs_bfs_unit");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		hold_cycles = 0;
		idle_pct = 23;
		vcount = gtu_pkg::VCNT_RESET;
		foreach (degree[i]) degree[i] = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_limit();
		write_vcount(64);
		idle_pct = 0;
		test_random(100, 64);
		idle_pct = 23;
		test_backpressure();
		write_vcount(8);
		foreach (degree[i]) degree[i] = degree[i];
		test_random(150, 8);
		write_vcount(64);
		test_random(200, 64);
		drain();
		if (errors == 0) $display("PASS graph_traversal_dfs_bfs_unit");
		else $display("FAIL graph_traversal_dfs_bfs_unit");
		$finish;
	end
endmodule

FILE: files.f
design/gtu_pkg.sv
design/gtu_ram.sv
design/gtu_ctrl.sv
design/gtu_dp.sv
design/graph_traversal_dfs_bfs_unit.sv
bench/tb_top.sv
